// ----- src/stepper_phase_sequencer_defines.svh -----
// assertion macros for the stepper phase sequencer
`ifndef STEPPER_PHASE_SEQUENCER_DEFINES_SVH
`define STEPPER_PHASE_SEQUENCER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SPSQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spsq check failed");

// next-cycle implication, checked out of reset
`define SPSQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spsq check failed");

`endif

// ----- src/spsq_pkg.sv -----
package spsq_pkg;

    localparam int unsigned CountW = 16;
    localparam int unsigned CoilW  = 4;
    localparam int unsigned PhaseW = 3;

    localparam logic [CountW-1:0] TickMax = {CountW{1'b1}};

    // input mode codes
    typedef enum logic {
        MODE_TICK  = 1'b0,
        MODE_START = 1'b1
    } t_mode;

    typedef logic [CoilW-1:0] t_coil;

    // one result item
    typedef struct packed {
        t_coil coils;
        logic  busy;
        logic  done;
    } t_result;

    localparam t_coil WaveFwd [4] = '{4'd1, 4'd2, 4'd4, 4'd8};
    localparam t_coil WaveRev [4] = '{4'd8, 4'd4, 4'd2, 4'd1};
    localparam t_coil HalfFwd [8] = '{4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8, 4'd9};
    localparam t_coil HalfRev [8] = '{4'd8, 4'd12, 4'd4, 4'd6, 4'd2, 4'd3, 4'd1, 4'd9};

    // coil pattern for a sequence position
    function automatic t_coil pattern_at(input logic half, input logic rev,
                                         input logic [PhaseW-1:0] idx);
        t_coil pat;
        if (half) begin
            pat = rev ? HalfRev[idx] : HalfFwd[idx];
        end else begin
            pat = rev ? WaveRev[idx[1:0]] : WaveFwd[idx[1:0]];
        end
        return pat;
    endfunction

endpackage

// ----- src/stepper_phase_sequencer.sv -----
// accepted item's result is registered in r_out, or in the skid stage if output is held
// one item per cycle while o_ready; a skid stage keeps input ready for one stalled result
// state advances in a single pass of short logic at item acceptance
// reset (synchronous, active low) clears the move state, coils off, and empties outputs
`include "stepper_phase_sequencer_defines.svh"

module stepper_phase_sequencer
    import spsq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_mode,
    input  logic [CountW-1:0] i_step_count,
    input  logic              i_direction,
    input  logic              i_half_step,
    input  logic [CountW-1:0] i_hold_time,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CoilW-1:0]  o_coils,
    output logic              o_busy_res,
    output logic              o_done_res
);

    // move state
    logic [PhaseW-1:0] r_phase, n_phase;
    logic [CountW-1:0] r_steps, n_steps;
    logic [CountW-1:0] r_elapsed, n_elapsed;
    logic [CountW-1:0] r_hold, n_hold;
    logic              r_busy, n_busy;
    logic              r_half, n_half;
    logic              r_rev, n_rev;
    t_coil             r_coil, n_coil;
    logic              n_done;

    // output register and skid stage
    t_result r_out, r_skid, n_res;
    logic    r_out_valid, r_skid_valid;

    logic              accept, take, start;
    logic [CountW-1:0] hold_sel, elapsed_inc, steps_dec;
    logic [PhaseW-1:0] phase_inc;

    assign o_ready = !r_skid_valid;
    assign accept  = i_valid && o_ready;
    assign take    = r_out_valid && i_ready;
    assign start   = (t_mode'(i_mode) == MODE_START) && !r_busy;

    // start-item hold time, halved in half step and at least one tick
    always_comb begin
        hold_sel = i_half_step ? (i_hold_time >> 1) : i_hold_time;
        if (hold_sel == '0) begin
            hold_sel = CountW'(1);
        end
    end

    assign elapsed_inc = (r_elapsed != TickMax) ? r_elapsed + CountW'(1) : r_elapsed;
    assign steps_dec   = r_steps - CountW'(1);
    assign phase_inc   = r_phase + PhaseW'(1);

    // next move state for the item at the input
    always_comb begin
        n_phase   = r_phase;
        n_steps   = r_steps;
        n_elapsed = r_elapsed;
        n_hold    = r_hold;
        n_busy    = r_busy;
        n_half    = r_half;
        n_rev     = r_rev;
        n_coil    = r_coil;
        n_done    = 1'b0;
        if (start) begin
            n_rev     = i_direction;
            n_half    = i_half_step;
            n_hold    = hold_sel;
            n_elapsed = '0;
            n_phase   = '0;
            if (i_step_count == '0) begin
                n_steps = '0;
                n_coil  = '0;
                n_busy  = 1'b0;
                n_done  = 1'b1;
            end else begin
                n_steps = i_step_count;
                n_coil  = pattern_at(i_half_step, i_direction, '0);
                n_busy  = 1'b1;
            end
        end else if (r_busy) begin
            n_elapsed = elapsed_inc;
            if (elapsed_inc >= r_hold) begin
                n_elapsed = '0;
                n_steps   = steps_dec;
                if (steps_dec == '0) begin
                    n_coil = '0;
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end else begin
                    n_phase = phase_inc;
                    n_coil  = pattern_at(r_half, r_rev, phase_inc);
                end
            end
        end
        n_res = '{coils: n_coil, busy: n_busy, done: n_done};
    end

    // move state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_steps   <= '0;
            r_elapsed <= '0;
            r_hold    <= '0;
            r_busy    <= 1'b0;
            r_half    <= 1'b0;
            r_rev     <= 1'b0;
            r_coil    <= '0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_steps   <= n_steps;
            r_elapsed <= n_elapsed;
            r_hold    <= n_hold;
            r_busy    <= n_busy;
            r_half    <= n_half;
            r_rev     <= n_rev;
            r_coil    <= n_coil;
        end
    end

    // output valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !take) begin
            if (accept) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= accept;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (r_out_valid && !take) begin
            if (accept) begin
                r_skid <= n_res;
            end
        end else if (r_skid_valid) begin
            r_out <= r_skid;
        end else if (accept) begin
            r_out <= n_res;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_coils    = r_out.coils;
    assign o_busy_res = r_out.busy;
    assign o_done_res = r_out.done;

    // skid stage only fills behind a held output
    `SPSQ_ASSERT_NOW(a_skid_order, r_skid_valid, r_out_valid)
    // a running move always drives a coil
    `SPSQ_ASSERT_NOW(a_busy_coils, r_busy, r_coil != '0)
    // a tick while idle leaves the coils off
    `SPSQ_ASSERT_NEXT(a_idle_tick, accept && !i_mode && !r_busy, !r_busy && r_coil == '0)

endmodule

// ----- verif/stepper_phase_sequencer_tb.sv -----
`timescale 1ns / 1ps

module stepper_phase_sequencer_tb
    import spsq_pkg::*;
;

    // coil sequences packed low nibble first
    localparam logic [15:0] WaveFwdSeq = {4'd8, 4'd4, 4'd2, 4'd1};
    localparam logic [15:0] WaveRevSeq = {4'd1, 4'd2, 4'd4, 4'd8};
    localparam logic [31:0] HalfFwdSeq = {4'd9, 4'd8, 4'd12, 4'd4, 4'd6, 4'd2, 4'd3, 4'd1};
    localparam logic [31:0] HalfRevSeq = {4'd9, 4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8};

    localparam int RandomItems = 1700;
    localparam int QuietFrom   = 1500;

    // tracks the move state and holds the coil drive results still due
    class coil_drive_tracker;
        logic [PhaseW-1:0] phase;
        logic [CountW-1:0] steps_left;
        logic [CountW-1:0] elapsed;
        logic [CountW-1:0] hold_limit;
        logic              busy;
        logic              half;
        logic              rev;
        t_coil             coil;
        t_result           drive_due[$];
        int                drive_errors;

        function new();
            phase        = '0;
            steps_left   = '0;
            elapsed      = '0;
            hold_limit   = '0;
            busy         = 1'b0;
            half         = 1'b0;
            rev          = 1'b0;
            coil         = '0;
            drive_errors = 0;
        endfunction

        function t_coil coil_for(logic [PhaseW-1:0] idx);
            t_coil pat;
            if (half) begin
                pat = rev ? HalfRevSeq[{idx, 2'b00} +: 4] : HalfFwdSeq[{idx, 2'b00} +: 4];
            end else begin
                pat = rev ? WaveRevSeq[{idx[1:0], 2'b00} +: 4]
                          : WaveFwdSeq[{idx[1:0], 2'b00} +: 4];
            end
            return pat;
        endfunction

        // advance the move by one accepted item and queue its result
        function void note_item(t_mode mode, logic [CountW-1:0] cnt, logic dir,
                                logic half_in, logic [CountW-1:0] hold);
            logic [CountW-1:0] lim;
            logic              ended;
            t_result           res;
            ended = 1'b0;
            if (mode == MODE_START && !busy) begin
                rev  = dir;
                half = half_in;
                lim  = half_in ? (hold >> 1) : hold;
                if (lim == '0) begin
                    lim = CountW'(1);
                end
                hold_limit = lim;
                elapsed    = '0;
                phase      = '0;
                if (cnt == '0) begin
                    steps_left = '0;
                    coil       = '0;
                    busy       = 1'b0;
                    ended      = 1'b1;
                end else begin
                    steps_left = cnt;
                    coil       = coil_for('0);
                    busy       = 1'b1;
                end
            end else if (busy) begin
                // tick, or a start ignored while busy
                if (elapsed != TickMax) begin
                    elapsed = elapsed + 1'b1;
                end
                if (elapsed >= hold_limit) begin
                    elapsed    = '0;
                    steps_left = steps_left - 1'b1;
                    if (steps_left == '0) begin
                        coil  = '0;
                        busy  = 1'b0;
                        ended = 1'b1;
                    end else begin
                        phase = phase + 1'b1;
                        coil  = coil_for(phase);
                    end
                end
            end
            res.coils = coil;
            res.busy  = busy;
            res.done  = ended;
            drive_due.push_back(res);
        endfunction

        // compare one result item against the oldest one due
        function void check_drive(t_result got);
            t_result want;
            if (drive_due.size() == 0) begin
                drive_errors++;
                if (drive_errors <= 10) begin
                    $display("unexpected result: coils %0d busy %0b done %0b",
                             got.coils, got.busy, got.done);
                end
                return;
            end
            want = drive_due.pop_front();
            if (got.coils !== want.coils || got.busy !== want.busy
                    || got.done !== want.done) begin
                drive_errors++;
                if (drive_errors <= 10) begin
                    $display("mismatch (exp/got): coils %0d/%0d busy %0b/%0b done %0b/%0b",
                             want.coils, got.coils, want.busy, got.busy,
                             want.done, got.done);
                end
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic              i_mode;
    logic [CountW-1:0] i_step_count;
    logic              i_direction;
    logic              i_half_step;
    logic [CountW-1:0] i_hold_time;
    logic              o_valid;
    logic              i_ready;
    logic [CoilW-1:0]  o_coils;
    logic              o_busy_res;
    logic              o_done_res;

    coil_drive_tracker tracker = new();
    bit                quiet = 1'b0;
    int                stall_left = 0;
    int                items_sent = 0;

    stepper_phase_sequencer u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_step_count (i_step_count),
        .i_direction  (i_direction),
        .i_half_step  (i_half_step),
        .i_hold_time  (i_hold_time),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_coils      (o_coils),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result side back-pressure in short bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 99) < 15) begin
            i_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // watch both handshakes
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                tracker.note_item(t_mode'(i_mode), i_step_count, i_direction,
                                  i_half_step, i_hold_time);
            end
            if (o_valid && i_ready) begin
                got.coils = o_coils;
                got.busy  = o_busy_res;
                got.done  = o_done_res;
                tracker.check_drive(got);
            end
        end
    end

    // present one item and hold it until accepted
    task automatic send_item(input t_mode mode, input logic [CountW-1:0] cnt,
                             input logic dir, input logic half,
                             input logic [CountW-1:0] hold);
        if (!quiet && $urandom_range(0, 99) < 15) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_step_count <= cnt;
        i_direction  <= dir;
        i_half_step  <= half;
        i_hold_time  <= hold;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // tick item with junk in the fields that a tick ignores
    task automatic send_tick();
        send_item(MODE_TICK, CountW'($urandom), 1'($urandom), 1'($urandom),
                  CountW'($urandom));
    endtask

    // start a move, then feed the ticks that finish it; noise_pct of them
    // are random starts that land while busy
    task automatic run_move(input logic [CountW-1:0] cnt, input logic dir,
                            input logic half, input logic [CountW-1:0] hold,
                            input int noise_pct);
        int unsigned lim;
        int unsigned ticks;
        lim = 32'(half ? (hold >> 1) : hold);
        if (lim == 0) begin
            lim = 1;
        end
        ticks = cnt * lim;
        send_item(MODE_START, cnt, dir, half, hold);
        for (int unsigned k = 0; k < ticks; k++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_item(MODE_START, CountW'($urandom), 1'($urandom), 1'($urandom),
                          CountW'($urandom));
            end else begin
                send_tick();
            end
        end
    endtask

    task automatic wait_drained();
        while (tracker.drive_due.size() != 0) @(posedge i_clk);
    endtask

    // main sequence
    initial begin
        logic [CountW-1:0] cnt;
        logic [CountW-1:0] hold;
        int                pick;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_ready      = 1'b0;
        i_mode       = MODE_TICK;
        i_step_count = '0;
        i_direction  = 1'b0;
        i_half_step  = 1'b0;
        i_hold_time  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle tick, zero count, zero hold, each sequence
        send_tick();
        send_item(MODE_START, 16'd0, 1'b1, 1'b1, 16'hFFFF);
        run_move(16'd5, 1'b0, 1'b0, 16'd0, 0);
        run_move(16'd9, 1'b0, 1'b1, 16'd1, 0);
        run_move(16'd4, 1'b1, 1'b0, 16'd3, 0);
        run_move(16'd10, 1'b1, 1'b1, 16'd5, 0);
        run_move(16'd6, 1'b1, 1'b1, 16'd4, 40);
        send_tick();
        // long count and long hold
        run_move(16'd120, 1'b0, 1'b1, 16'd0, 0);
        run_move(16'd1, 1'b0, 1'b0, 16'd250, 0);
        run_move(16'd3, 1'b1, 1'b0, 16'd2, 0);

        // let every result drain before the random part
        i_valid <= 1'b0;
        wait_drained();
        repeat ($urandom_range(1, 4)) @(posedge i_clk);

        while (items_sent < RandomItems) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_item(MODE_START, '0, 1'($urandom), 1'($urandom), CountW'($urandom));
            end else if (pick < 14) begin
                send_tick();
            end else begin
                cnt  = ($urandom_range(0, 9) == 0) ? CountW'($urandom_range(13, 40))
                                                   : CountW'($urandom_range(1, 12));
                hold = ($urandom_range(0, 9) == 0) ? CountW'($urandom_range(7, 20))
                                                   : CountW'($urandom_range(0, 6));
                run_move(cnt, 1'($urandom), 1'($urandom), hold, 8);
            end
            if (items_sent >= QuietFrom) begin
                quiet = 1'b1;
            end
        end
        i_valid <= 1'b0;

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (tracker.drive_errors == 0 && tracker.drive_due.size() == 0) begin
            $display("stepper_phase_sequencer_tb: done, clean");
        end else begin
            $display("stepper_phase_sequencer_tb: done, errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("stepper_phase_sequencer_tb: done, errors");
        $finish;
    end

endmodule

// ----- stepper_phase_sequencer.f -----
+incdir+src
src/spsq_pkg.sv
src/stepper_phase_sequencer.sv
verif/stepper_phase_sequencer_tb.sv
